/* sv/mna_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mna_pkg;

  localparam int PART_WIDTH_DEF = 16;
  localparam int WHOLE_W        = 19;
  localparam int WORD_W         = 32;

  localparam int PC_W   = 4;
  localparam int OP_W   = 4;
  localparam int COND_W = 3;

  localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL0     = 4'd2;
  localparam logic [OP_W-1:0] OP_MUL1     = 4'd3;
  localparam logic [OP_W-1:0] OP_MUL2     = 4'd4;
  localparam logic [OP_W-1:0] OP_DIV_N    = 4'd5;
  localparam logic [OP_W-1:0] OP_DIV_STEP = 4'd6;
  localparam logic [OP_W-1:0] OP_GCD_INIT = 4'd7;
  localparam logic [OP_W-1:0] OP_GCD_STEP = 4'd8;
  localparam logic [OP_W-1:0] OP_DIV_D    = 4'd9;
  localparam logic [OP_W-1:0] OP_DIV_R    = 4'd10;
  localparam logic [OP_W-1:0] OP_EMIT     = 4'd11;

  localparam logic [COND_W-1:0] COND_NEVER    = 3'd0;
  localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd1;
  localparam logic [COND_W-1:0] COND_NO_IN    = 3'd2;
  localparam logic [COND_W-1:0] COND_ERR      = 3'd3;
  localparam logic [COND_W-1:0] COND_CNT_MORE = 3'd4;
  localparam logic [COND_W-1:0] COND_V_NZ     = 3'd5;
  localparam logic [COND_W-1:0] COND_OUT_BUSY = 3'd6;

  localparam logic [PC_W-1:0] PC_WAIT = 4'd0;
  localparam logic [PC_W-1:0] PC_DIVN = 4'd6;
  localparam logic [PC_W-1:0] PC_GCD  = 4'd8;
  localparam logic [PC_W-1:0] PC_DIVD = 4'd10;
  localparam logic [PC_W-1:0] PC_DIVR = 4'd12;
  localparam logic [PC_W-1:0] PC_EMIT = 4'd13;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } ctrl_t;

  function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      4'd0:    w = '{OP_LOAD,     COND_NO_IN,    PC_WAIT};
      4'd1:    w = '{OP_NOP,      COND_ERR,      PC_EMIT};
      4'd2:    w = '{OP_MUL0,     COND_NEVER,    PC_WAIT};
      4'd3:    w = '{OP_MUL1,     COND_NEVER,    PC_WAIT};
      4'd4:    w = '{OP_MUL2,     COND_NEVER,    PC_WAIT};
      4'd5:    w = '{OP_DIV_N,    COND_NEVER,    PC_WAIT};
      4'd6:    w = '{OP_DIV_STEP, COND_CNT_MORE, PC_DIVN};
      4'd7:    w = '{OP_GCD_INIT, COND_NEVER,    PC_WAIT};
      4'd8:    w = '{OP_GCD_STEP, COND_V_NZ,     PC_GCD};
      4'd9:    w = '{OP_DIV_D,    COND_NEVER,    PC_WAIT};
      4'd10:   w = '{OP_DIV_STEP, COND_CNT_MORE, PC_DIVD};
      4'd11:   w = '{OP_DIV_R,    COND_NEVER,    PC_WAIT};
      4'd12:   w = '{OP_DIV_STEP, COND_CNT_MORE, PC_DIVR};
      4'd13:   w = '{OP_EMIT,     COND_OUT_BUSY, PC_EMIT};
      default: w = '{OP_NOP,      COND_ALWAYS,   PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* sv/mixed_number_adder.sv */
// An accepted word runs the ROM program: three multiplies, a divide for the whole
// part, a binary GCD loop and divides of denominator and remainder by the GCD, with
// NW = 2*PART_WIDTH+1; the shared one-bit-per-cycle divider makes three runs of NW steps.
// No new word is taken until the program is back at wait; a zero denominator goes to emit.
// Reset (rst_n low, synchronous) clears the program counter and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module mixed_number_adder
  import mna_pkg::*;
#(
  parameter int PART_WIDTH = PART_WIDTH_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire  signed [PART_WIDTH-1:0] in_a_whole,
  input  wire         [PART_WIDTH-1:0] in_a_num,
  input  wire         [PART_WIDTH-1:0] in_a_den,
  input  wire  signed [PART_WIDTH-1:0] in_b_whole,
  input  wire         [PART_WIDTH-1:0] in_b_num,
  input  wire         [PART_WIDTH-1:0] in_b_den,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic signed [WHOLE_W-1:0]   out_sum_whole,
  output logic        [WORD_W-1:0]    out_sum_num,
  output logic        [WORD_W-1:0]    out_sum_den,
  output logic                        out_div_error
);

  localparam int W     = PART_WIDTH;
  localparam int NW    = 2 * W + 1;
  localparam int CNT_W = $clog2(NW + 1);

  logic [PC_W-1:0] pc_r, pc_nxt;
  ctrl_t           cw;
  logic            cond_hit;

  logic signed [W-1:0] aw_r, bw_r;
  logic [W-1:0]        an_r, ad_r, bn_r, bd_r;
  logic                err_r;

  logic [2*W-1:0]   p_r, p_nxt;
  logic [NW-1:0]    n_r, n_nxt;
  logic [NW-1:0]    q_r, q_nxt;
  logic [NW-1:0]    rem_r, rem_nxt;
  logic [NW-1:0]    dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0]    u_r, u_nxt, v_r, v_nxt;
  logic [NW-1:0]    dc_r, dc_nxt, rc_r, rc_nxt;
  logic [WHOLE_W-1:0] wq_r, wq_nxt;
  logic [WORD_W-1:0]  den_r, den_nxt;

  logic [W-1:0]     mul_a, mul_b;
  logic [NW:0]      sh;
  logic             ge;
  logic             gt;
  logic [NW-1:0]    big, sml;
  logic [63:0]      q64;
  logic [63:0]      whole64;
  logic             out_free;
  logic             emit;
  logic             in_acc;

  logic                      out_valid_r;
  logic signed [WHOLE_W-1:0] o_whole_r;
  logic [WORD_W-1:0]         o_num_r, o_den_r;
  logic                      o_err_r;

  assign cw       = rom_word(pc_r);
  assign in_stall = (pc_r != PC_WAIT);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = (cw.op == OP_EMIT) && out_free;

  always_comb begin
    case (cw.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_NO_IN:    cond_hit = !in_valid;
      COND_ERR:      cond_hit = err_r;
      COND_CNT_MORE: cond_hit = (cnt_r != CNT_W'(1));
      COND_V_NZ:     cond_hit = (v_r != '0);
      COND_OUT_BUSY: cond_hit = !out_free;
      default:       cond_hit = 1'b0;
    endcase
    pc_nxt = cond_hit ? cw.target : pc_r + PC_W'(1);
  end

  always_comb begin
    case (cw.op)
      OP_MUL0: begin
        mul_a = an_r;
        mul_b = bd_r;
      end
      OP_MUL1: begin
        mul_a = bn_r;
        mul_b = ad_r;
      end
      default: begin
        mul_a = ad_r;
        mul_b = bd_r;
      end
    endcase
  end

  assign sh  = {rem_r, q_r[NW-1]};
  assign ge  = (sh >= {1'b0, dvs_r});
  assign gt  = (u_r > v_r);
  assign big = gt ? u_r : v_r;
  assign sml = gt ? v_r : u_r;
  assign q64 = 64'(q_r);
  assign whole64 = 64'(aw_r) + 64'(bw_r) + 64'(wq_r);

  always_comb begin
    p_nxt   = p_r;
    n_nxt   = n_r;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    u_nxt   = u_r;
    v_nxt   = v_r;
    dc_nxt  = dc_r;
    rc_nxt  = rc_r;
    wq_nxt  = wq_r;
    den_nxt = den_r;
    case (cw.op)
      OP_MUL0: begin
        p_nxt = mul_a * mul_b;
      end
      OP_MUL1: begin
        n_nxt = NW'(p_r);
        p_nxt = mul_a * mul_b;
      end
      OP_MUL2: begin
        n_nxt = n_r + NW'(p_r);
        p_nxt = mul_a * mul_b;
      end
      OP_DIV_N: begin
        q_nxt   = n_r;
        rem_nxt = '0;
        dvs_nxt = NW'(p_r);
        cnt_nxt = CNT_W'(NW);
      end
      OP_DIV_STEP: begin
        q_nxt   = {q_r[NW-2:0], ge};
        rem_nxt = ge ? NW'(sh - {1'b0, dvs_r}) : sh[NW-1:0];
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      OP_GCD_INIT: begin
        wq_nxt = q64[WHOLE_W-1:0];
        u_nxt  = dvs_r;
        dc_nxt = dvs_r;
        v_nxt  = rem_r;
        rc_nxt = rem_r;
      end
      OP_GCD_STEP: begin
        if (v_r != '0) begin
          if (!u_r[0] && !v_r[0]) begin
            u_nxt  = u_r >> 1;
            v_nxt  = v_r >> 1;
            dc_nxt = dc_r >> 1;
            rc_nxt = rc_r >> 1;
          end else if (!u_r[0]) begin
            u_nxt = u_r >> 1;
          end else if (!v_r[0]) begin
            v_nxt = v_r >> 1;
          end else begin
            u_nxt = sml;
            v_nxt = big - sml;
          end
        end
      end
      OP_DIV_D: begin
        q_nxt   = dc_r;
        rem_nxt = '0;
        dvs_nxt = u_r;
        cnt_nxt = CNT_W'(NW);
      end
      OP_DIV_R: begin
        den_nxt = q64[WORD_W-1:0];
        q_nxt   = rc_r;
        rem_nxt = '0;
        dvs_nxt = u_r;
        cnt_nxt = CNT_W'(NW);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((cw.op == OP_LOAD) && in_acc) begin
      aw_r  <= in_a_whole;
      an_r  <= in_a_num;
      ad_r  <= in_a_den;
      bw_r  <= in_b_whole;
      bn_r  <= in_b_num;
      bd_r  <= in_b_den;
      err_r <= (in_a_den == '0) || (in_b_den == '0);
    end
    p_r   <= p_nxt;
    n_r   <= n_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    u_r   <= u_nxt;
    v_r   <= v_nxt;
    dc_r  <= dc_nxt;
    rc_r  <= rc_nxt;
    wq_r  <= wq_nxt;
    den_r <= den_nxt;
    if (emit) begin
      if (err_r) begin
        o_whole_r <= '0;
        o_num_r   <= '0;
        o_den_r   <= '0;
        o_err_r   <= 1'b1;
      end else begin
        o_whole_r <= whole64[WHOLE_W-1:0];
        o_num_r   <= q64[WORD_W-1:0];
        o_den_r   <= den_r;
        o_err_r   <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sum_whole = o_whole_r;
  assign out_sum_num   = o_num_r;
  assign out_sum_den   = o_den_r;
  assign out_div_error = o_err_r;

endmodule

`default_nettype wire

/* dv/tb_mixed_number_adder.sv */
`timescale 1ns / 1ps

module tb_mixed_number_adder;
  import mna_pkg::*;

  localparam int PW = PART_WIDTH_DEF;

  typedef struct {
    logic signed [PW-1:0] a_whole;
    logic [PW-1:0]        a_num;
    logic [PW-1:0]        a_den;
    logic signed [PW-1:0] b_whole;
    logic [PW-1:0]        b_num;
    logic [PW-1:0]        b_den;
  } mixed_pair_t;

  typedef struct {
    logic signed [WHOLE_W-1:0] sum_whole;
    logic [WORD_W-1:0]         sum_num;
    logic [WORD_W-1:0]         sum_den;
    logic                      div_error;
  } mixed_sum_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [PW-1:0] in_a_whole = '0;
  logic [PW-1:0] in_a_num = '0;
  logic [PW-1:0] in_a_den = '0;
  logic signed [PW-1:0] in_b_whole = '0;
  logic [PW-1:0] in_b_num = '0;
  logic [PW-1:0] in_b_den = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [WHOLE_W-1:0] out_sum_whole;
  logic [WORD_W-1:0] out_sum_num;
  logic [WORD_W-1:0] out_sum_den;
  logic out_div_error;

  mixed_pair_t pending_pairs[$];
  mixed_sum_t expected_sums[$];
  mixed_pair_t cur_pair;
  int idle_pct = 0;
  int stall_pct = 0;
  int fault_count = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_cnt = 0;

  mixed_number_adder #(.PART_WIDTH(PW)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_a_whole(in_a_whole),
    .in_a_num(in_a_num),
    .in_a_den(in_a_den),
    .in_b_whole(in_b_whole),
    .in_b_num(in_b_num),
    .in_b_den(in_b_den),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sum_whole(out_sum_whole),
    .out_sum_num(out_sum_num),
    .out_sum_den(out_sum_den),
    .out_div_error(out_div_error)
  );

  always #5 clk = ~clk;

  function automatic mixed_sum_t add_mixed(mixed_pair_t p);
    mixed_sum_t r;
    longint unsigned n, d, x, y, t;
    longint w;
    r.sum_whole = '0;
    r.sum_num = '0;
    r.sum_den = '0;
    r.div_error = 1'b0;
    if (p.a_den == 0 || p.b_den == 0) begin
      r.div_error = 1'b1;
      return r;
    end
    n = 64'(p.a_num) * 64'(p.b_den) + 64'(p.b_num) * 64'(p.a_den);
    d = 64'(p.a_den) * 64'(p.b_den);
    x = d;
    y = n;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    n = n / x;
    d = d / x;
    w = longint'(p.a_whole) + longint'(p.b_whole) + longint'(n / d);
    r.sum_whole = w[WHOLE_W-1:0];
    r.sum_num = 32'(n % d);
    r.sum_den = d[WORD_W-1:0];
    return r;
  endfunction

  function automatic logic [PW-1:0] rand_part(bit nonzero);
    logic [PW-1:0] v;
    case ($urandom_range(3))
      0: v = PW'($urandom_range(16));
      1: v = PW'($urandom_range(255));
      2: v = PW'($urandom_range(65535, 65000));
      default: v = PW'($urandom());
    endcase
    if (nonzero && v == 0) v = 1;
    return v;
  endfunction

  function automatic mixed_pair_t rand_pair();
    mixed_pair_t p;
    int kind;
    kind = $urandom_range(99);
    p.a_whole = PW'($urandom());
    p.b_whole = PW'($urandom());
    p.a_num = rand_part(1'b0);
    p.b_num = rand_part(1'b0);
    p.a_den = rand_part(1'b1);
    p.b_den = rand_part(1'b1);
    if (kind < 4) p.a_den = '0;
    else if (kind < 8) p.b_den = '0;
    else if (kind < 10) begin
      p.a_den = '0;
      p.b_den = '0;
    end else if (kind < 25) p.b_den = p.a_den;
    else if (kind < 32) begin
      p.a_num = '0;
      p.b_num = '0;
    end
    return p;
  endfunction

  function automatic void push_pair(int aw, int an, int ad, int bw, int bn, int bd);
    mixed_pair_t p;
    p.a_whole = PW'(aw);
    p.a_num = PW'(an);
    p.a_den = PW'(ad);
    p.b_whole = PW'(bw);
    p.b_num = PW'(bn);
    p.b_den = PW'(bd);
    pending_pairs.push_back(p);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_sums.push_back(add_mixed(cur_pair));
      if (!in_valid || !in_stall) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur_pair = pending_pairs.pop_front();
          in_a_whole <= cur_pair.a_whole;
          in_a_num <= cur_pair.a_num;
          in_a_den <= cur_pair.a_den;
          in_b_whole <= cur_pair.b_whole;
          in_b_num <= cur_pair.b_num;
          in_b_den <= cur_pair.b_den;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= (hold_cnt != 1);
    end else if (hold_req && !hold_done) begin
      hold_cnt <= 3000;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_sums
    mixed_sum_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        $error("unexpected word: sum_whole %0d, sum_num %0d, sum_den %0d",
               out_sum_whole, out_sum_num, out_sum_den);
        fault_count++;
      end else begin
        want = expected_sums.pop_front();
        if (out_sum_whole !== want.sum_whole) begin
          $error("sum_whole: expected %0d, got %0d", want.sum_whole, out_sum_whole);
          fault_count++;
        end
        if (out_sum_num !== want.sum_num) begin
          $error("sum_num: expected %0d, got %0d", want.sum_num, out_sum_num);
          fault_count++;
        end
        if (out_sum_den !== want.sum_den) begin
          $error("sum_den: expected %0d, got %0d", want.sum_den, out_sum_den);
          fault_count++;
        end
        if (out_div_error !== want.div_error) begin
          $error("div_error: expected %0d, got %0d", want.div_error, out_div_error);
          fault_count++;
        end
      end
    end
  end

  task automatic drain();
    do @(negedge clk);
    while (pending_pairs.size() != 0 || in_valid || expected_sums.size() != 0);
  endtask

  task automatic run_phase(int count, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) pending_pairs.push_back(rand_pair());
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    push_pair(0, 0, 1, 0, 0, 1);
    push_pair(-32768, 0, 1, -32768, 0, 1);
    push_pair(32767, 65535, 1, 32767, 65535, 1);
    push_pair(32767, 65535, 65535, 32767, 65535, 65535);
    push_pair(-32768, 65534, 65535, -32768, 65534, 65535);
    push_pair(5, 3, 0, 2, 1, 4);
    push_pair(5, 3, 4, 2, 1, 0);
    push_pair(-7, 0, 0, 9, 65535, 0);
    push_pair(12, 0, 7, -3, 0, 65535);
    push_pair(1, 1, 2, 1, 1, 2);
    push_pair(-1, 1, 3, -2, 2, 3);
    push_pair(0, 7, 3, 0, 11, 5);
    push_pair(0, 1, 65535, 0, 1, 65534);
    push_pair(100, 65535, 2, -100, 1, 65535);
    push_pair(-32768, 1, 65535, 32767, 65534, 65535);
    push_pair(3, 6, 4, 4, 10, 4);
    push_pair(0, 32768, 32768, 0, 0, 1);
    push_pair(21845, 43690, 21845, -21846, 21845, 43690);
    push_pair(-1, 65535, 65521, -1, 65521, 65535);
    push_pair(0, 0, 65535, 0, 65535, 1);
    drain();

    run_phase(80, 0, 0);
    run_phase(75, 72, 0);
    run_phase(75, 0, 72);
    run_phase(75, 27, 27);

    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    repeat (70) pending_pairs.push_back(rand_pair());
    drain();

    repeat (300) @(posedge clk);
    if (fault_count == 0 && expected_sums.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* mixed_number_adder.f */
sv/mna_pkg.sv
sv/mixed_number_adder.sv
dv/tb_mixed_number_adder.sv
